// ----- rtl/brd_pkg.sv -----
package brd_pkg;

    localparam int unsigned LANES = 16;
    localparam int unsigned CNT_W = 15;
    localparam int unsigned BASE_W = 9;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 2'd1;

    // rate select codes for outputs 1 to 14
    localparam logic [1:0] RATE_X1 = 2'd0;
    localparam logic [1:0] RATE_X8 = 2'd1;
    localparam logic [1:0] RATE_X16 = 2'd2;
    localparam logic [1:0] RATE_X64 = 2'd3;

    localparam logic [LANES-1:0] RESET_LEVELS_ALL = 16'hC000;

    localparam logic [BASE_W-1:0] BASE_DIV [LANES] = '{
        9'd3, 9'd4, 9'd6, 9'd8, 9'd12, 9'd16, 9'd24, 9'd48,
        9'd96, 9'd144, 9'd192, 9'd214, 9'd262, 9'd384, 9'd2, 9'd1
    };

    typedef struct packed {
        logic half_tick;
        logic reset_line;
    } item_t;

    typedef struct packed {
        logic [LANES-1:0] out_levels;
        logic [LANES-1:0] toggled;
    } result_t;

    // per-lane control, shared by all dividers
    typedef struct packed {
        logic step;
        logic tick;
        logic rst;
        logic clear;
    } lane_ctrl_t;

    // terminal count (divisor minus one) of a lane at a given rate select
    function automatic logic [CNT_W-1:0] lane_limit(input logic [3:0] idx,
                                                    input logic [1:0] rate);
        logic [CNT_W-1:0] d;
        d = {{(CNT_W-BASE_W){1'b0}}, BASE_DIV[idx]};
        if (idx < 4'd14)
        begin
            case (rate)
                RATE_X1: d = d << 6;
                RATE_X8: d = d << 3;
                RATE_X16: d = d << 2;
                RATE_X64: d = d;
                default: d = d;
            endcase
        end
        return d - 15'd1;
    endfunction

endpackage

// ----- rtl/bit_rate_divider_bank.sv -----
// throughput: one request per cycle while out_ready does not stall the result register;
// all dividers compare and count in parallel, so the counter/level update between
// input and result register sets the rate
// reset (rst_n, async): outputs 1 to 14 low, 15 and 16 high, counters cleared,
// rate select x1, all outputs enabled, both pipeline registers empty
module bit_rate_divider_bank
    import brd_pkg::*;
#(
    parameter int unsigned NUM_OUTPUTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  item_t                 in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output result_t               out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // outputs that exist in this build
    localparam logic [LANES-1:0] OUT_MASK = LANES'((32'd1 << NUM_OUTPUTS) - 32'd1);
    localparam logic [LANES-1:0] RESET_LEVELS = RESET_LEVELS_ALL & OUT_MASK;

    // configuration registers
    logic [1:0]       rate_sel_reg;
    logic [LANES-1:0] enable_mask_reg;
    logic             rate_clear;

    // input stage
    logic  in_valid_reg;
    item_t in_data_reg;

    // result stage
    logic    out_valid_reg;
    result_t out_data_reg;

    // output levels
    logic [LANES-1:0] levels_reg;
    logic [LANES-1:0] levels_next;
    logic [LANES-1:0] toggle_vec;

    logic       advance;
    lane_ctrl_t lane_ctrl;

    // request moves from the input stage into the result stage
    assign advance = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign cfg_ready = 1'b1;

    // a changed rate restarts every running divider
    assign rate_clear = cfg_valid && (cfg_index == CFG_RATE_SELECT)
                        && (cfg_data[1:0] != rate_sel_reg);

    assign lane_ctrl.step = advance;
    assign lane_ctrl.tick = in_data_reg.half_tick;
    assign lane_ctrl.rst = in_data_reg.reset_line;
    assign lane_ctrl.clear = rate_clear;

    // one divider per output; missing outputs never toggle
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        if (i < NUM_OUTPUTS)
        begin : g_on
            brd_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (lane_ctrl),
                .enable (enable_mask_reg[i]),
                .limit  (lane_limit(4'(i), rate_sel_reg)),
                .toggle (toggle_vec[i])
            );
        end
        else
        begin : g_off
            assign toggle_vec[i] = 1'b0;
        end
    end

    // reset request wins over the half tick
    always_comb
    begin
        if (in_data_reg.reset_line)
        begin
            levels_next = RESET_LEVELS;
        end
        else
        begin
            levels_next = (levels_reg ^ toggle_vec) & OUT_MASK;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_sel_reg <= RATE_X1;
            enable_mask_reg <= '1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RATE_SELECT: rate_sel_reg <= cfg_data[1:0];
                CFG_ENABLE_MASK: enable_mask_reg <= cfg_data[LANES-1:0];
                default: ;
            endcase
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // level state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= RESET_LEVELS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                levels_reg <= levels_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.out_levels <= levels_next;
            out_data_reg.toggled <= (levels_next ^ levels_reg) & OUT_MASK;
        end
    end

    // a reset request always lands on the reset levels
    a_reset_levels: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_data_reg.reset_line
        |=> out_data_reg.out_levels == RESET_LEVELS)
        else $error("reset request did not give reset levels");

    // without a tick or reset nothing changes
    a_idle_no_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_data_reg.reset_line && !in_data_reg.half_tick
        |=> out_data_reg.toggled == '0)
        else $error("output changed without a half tick");

    // disabled outputs stay frozen outside reset
    a_disabled_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_data_reg.reset_line
        |=> (out_data_reg.toggled & ~$past(enable_mask_reg)) == '0)
        else $error("disabled output toggled");

endmodule

// ----- rtl/brd_lane.sv -----
module brd_lane
    import brd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_ctrl_t       ctrl,
    input  logic             enable,
    input  logic [CNT_W-1:0] limit,
    output logic             toggle
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             hit;

    assign hit = (cnt_reg >= limit);
    assign toggle = ctrl.step && !ctrl.rst && enable && ctrl.tick && hit;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.clear)
        begin
            cnt_next = '0;
        end
        else if (ctrl.step)
        begin
            if (ctrl.rst || !enable)
            begin
                cnt_next = '0;
            end
            else if (ctrl.tick)
            begin
                cnt_next = hit ? '0 : cnt_reg + 15'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- dv/bit_rate_divider_bank_tb.sv -----
module bit_rate_divider_bank_tb;
    import brd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // unused register slots, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // cycles to let pass after the last result before touching registers
    localparam int PIPE_SLACK = 4;

    // base divisors of F1 to F16, F15 and F16 never scaled
    localparam int DIVIDE_BASE [LANES] = '{
        3, 4, 6, 8, 12, 16, 24, 48, 96, 144, 192, 214, 262, 384, 2, 1
    };

    // directed table: plain requests, requests with a hand-typed result, register writes
    typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_CONFIG} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic                  tick;
        logic                  rst;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        result_t               want;
    } step_row_t;

    localparam int DIRECTED_ROWS = 33;
    localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
        // after reset, no tick: reset levels, nothing toggles
        '{ROW_CHECKED, 1'b0, 1'b0, CFG_RATE_SELECT, 16'h0000, '{16'hC000, 16'h0000}},
        // reset request on its own
        '{ROW_CHECKED, 1'b0, 1'b1, CFG_RATE_SELECT, 16'h0000, '{16'hC000, 16'h0000}},
        // first tick: only F16 (divide by one) flips
        '{ROW_CHECKED, 1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '{16'h4000, 16'h8000}},
        // second tick: F15 and F16 flip together
        '{ROW_CHECKED, 1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '{16'h8000, 16'hC000}},
        // reset wins over a tick in the same request
        '{ROW_CHECKED, 1'b1, 1'b1, CFG_RATE_SELECT, 16'h0000, '{16'hC000, 16'h4000}},
        // reset held
        '{ROW_CHECKED, 1'b0, 1'b1, CFG_RATE_SELECT, 16'h0000, '{16'hC000, 16'h0000}},
        '{ROW_CHECKED, 1'b0, 1'b0, CFG_RATE_SELECT, 16'h0000, '{16'hC000, 16'h0000}},
        // fastest rate, F1 divides by three
        '{ROW_CONFIG,  1'b0, 1'b0, CFG_RATE_SELECT, 16'(RATE_X64), '0},
        '{ROW_ITEM,    1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '0},
        '{ROW_ITEM,    1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '0},
        '{ROW_ITEM,    1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '0},
        // everything disabled: levels frozen
        '{ROW_CONFIG,  1'b0, 1'b0, CFG_ENABLE_MASK, 16'h0000, '0},
        '{ROW_ITEM,    1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '0},
        '{ROW_ITEM,    1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '0},
        '{ROW_CONFIG,  1'b0, 1'b0, CFG_ENABLE_MASK, 16'hFFFF, '0},
        // writes to unknown slots change nothing
        '{ROW_CONFIG,  1'b0, 1'b0, CFG_SPARE_2,     16'hFFFF, '0},
        '{ROW_CONFIG,  1'b0, 1'b0, CFG_SPARE_3,     16'h0000, '0},
        // same rate again must not restart the phases
        '{ROW_CONFIG,  1'b0, 1'b0, CFG_RATE_SELECT, 16'(RATE_X64), '0},
        '{ROW_ITEM,    1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '0},
        '{ROW_ITEM,    1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '0},
        // alternating masks
        '{ROW_CONFIG,  1'b0, 1'b0, CFG_ENABLE_MASK, 16'h5555, '0},
        '{ROW_ITEM,    1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '0},
        '{ROW_ITEM,    1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '0},
        '{ROW_CONFIG,  1'b0, 1'b0, CFG_ENABLE_MASK, 16'hAAAA, '0},
        '{ROW_ITEM,    1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '0},
        // the remaining rate codes, each one a change that restarts the phases
        '{ROW_CONFIG,  1'b0, 1'b0, CFG_RATE_SELECT, 16'(RATE_X1), '0},
        '{ROW_ITEM,    1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '0},
        '{ROW_CONFIG,  1'b0, 1'b0, CFG_RATE_SELECT, 16'(RATE_X8), '0},
        '{ROW_ITEM,    1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '0},
        '{ROW_CONFIG,  1'b0, 1'b0, CFG_RATE_SELECT, 16'(RATE_X16), '0},
        '{ROW_CONFIG,  1'b0, 1'b0, CFG_ENABLE_MASK, 16'hFFFF, '0},
        '{ROW_ITEM,    1'b1, 1'b0, CFG_RATE_SELECT, 16'h0000, '0},
        '{ROW_ITEM,    1'b0, 1'b0, CFG_RATE_SELECT, 16'h0000, '0}
    };

    // random phases: rate, mask (fixed or drawn) and request count per phase
    localparam int PHASES = 8;
    localparam logic [1:0] PHASE_RATE [PHASES] = '{
        RATE_X64, RATE_X16, RATE_X8, RATE_X1, RATE_X64, RATE_X8, RATE_X64, RATE_X16
    };
    localparam logic [15:0] PHASE_MASK [PHASES] = '{
        16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000
    };
    localparam bit PHASE_MASK_DRAWN [PHASES] = '{0, 1, 0, 0, 1, 1, 0, 1};
    localparam int PHASE_ITEMS [PHASES] = '{500, 120, 50, 130, 120, 120, 120, 90};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    item_t                 in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    result_t               out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predicted divider state
    logic [CNT_W-1:0] lane_count [LANES];
    logic [LANES-1:0] lane_levels;
    logic [LANES-1:0] lane_enable;
    logic [1:0]       cur_rate;

    // results still owed by the block, oldest first
    result_t levels_due [$];

    // traffic shaping, set by the stimulus thread
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int rx_hold_left = 0;

    int mismatch_count = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int slow_lane_flips = 0;

    bit_rate_divider_bank uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // effective half-period count of one lane at the current rate
    function automatic int lane_divisor(input int lane);
        int d;
        d = DIVIDE_BASE[lane];
        if (lane < 14)
        begin
            case (cur_rate)
                RATE_X1:  d = d * 64;
                RATE_X8:  d = d * 8;
                RATE_X16: d = d * 4;
                default:  d = d;
            endcase
        end
        return d;
    endfunction

    function automatic void clear_lane_counts();
        for (int i = 0; i < LANES; i++)
            lane_count[i] = '0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_RATE_SELECT:
            begin
                // only a real change restarts every phase
                if (value[1:0] != cur_rate)
                begin
                    cur_rate = value[1:0];
                    clear_lane_counts();
                end
            end
            CFG_ENABLE_MASK: lane_enable = value;
            default: ;
        endcase
    endfunction

    // one request through the divider bank, returns the levels and the flips
    function automatic result_t advance_dividers(input item_t it);
        result_t r;
        logic [LANES-1:0] prior;
        int c;
        prior = lane_levels;
        if (it.reset_line)
        begin
            lane_levels = RESET_LEVELS_ALL;
            clear_lane_counts();
        end
        else
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (!lane_enable[i])
                    lane_count[i] = '0;
                else if (it.half_tick)
                begin
                    c = int'(lane_count[i]) + 1;
                    if (c >= lane_divisor(i))
                    begin
                        lane_levels[i] = ~lane_levels[i];
                        c = 0;
                    end
                    lane_count[i] = CNT_W'(c);
                end
            end
        end
        r.out_levels = lane_levels;
        r.toggled = lane_levels ^ prior;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        $display("mismatch %0d: %s got %h want %h at %0t",
                 mismatch_count, what, got, want, $time);
    endtask

    // offer one request and hold it until taken, then now and then idle before the next one
    task automatic offer_item(input item_t it, input bit typed, input result_t typed_want);
        result_t predicted;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = advance_dividers(it);
        requests_sent++;
        levels_due.push_back(typed ? typed_want : predicted);
        if (!tx_calm && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stop offering and wait until every owed result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    // register writes only with the block idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        apply_register(idx, value);
        cfg_writes++;
    endtask

    // receiver: random stalls, a calm stretch, and a long counted hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                out_ready <= 1'b0;
                rx_hold_left--;
            end
            else if (rx_calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 9);
        end
    end

    // compare each taken result with the oldest owed one
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (out_data.toggled[13])
                slow_lane_flips++;
            if (levels_due.size() == 0)
                report_mismatch("result with nothing owed", out_data.out_levels, 16'h0000);
            else
            begin
                want = levels_due.pop_front();
                if (out_data.out_levels !== want.out_levels)
                    report_mismatch("out_levels", out_data.out_levels, want.out_levels);
                if (out_data.toggled !== want.toggled)
                    report_mismatch("toggled", out_data.toggled, want.toggled);
            end
        end
    end

    // stimulus
    initial
    begin
        item_t it;
        logic [15:0] mask;
        int reset_odds;

        // predictor starts from the reset state
        cur_rate = RATE_X1;
        lane_enable = 16'hFFFF;
        lane_levels = RESET_LEVELS_ALL;
        clear_lane_counts();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int row = 0; row < DIRECTED_ROWS; row++)
        begin
            it.half_tick = DIRECTED[row].tick;
            it.reset_line = DIRECTED[row].rst;
            case (DIRECTED[row].kind)
                ROW_CONFIG:  write_register(DIRECTED[row].idx, DIRECTED[row].data);
                ROW_CHECKED: offer_item(it, 1'b1, DIRECTED[row].want);
                default:     offer_item(it, 1'b0, '0);
            endcase
        end

        // random phases, mostly ticks so that slow lanes get to flip
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_register(CFG_RATE_SELECT, 16'(PHASE_RATE[phase]));
            mask = PHASE_MASK_DRAWN[phase] ? 16'($urandom_range(0, 65535)) : PHASE_MASK[phase];
            write_register(CFG_ENABLE_MASK, mask);
            tx_calm = (phase == 0);
            rx_calm = (phase == 0);
            // long receiver hold-off while requests keep coming, fills the pipe
            if (phase == 3)
                rx_hold_left = 80;
            // resets are rare in the first phase so the slowest lane can flip
            reset_odds = (phase == 0) ? 999 : 149;
            for (int k = 0; k < PHASE_ITEMS[phase]; k++)
            begin
                if (phase == 0 && k == 200)
                begin
                    tx_calm = 1'b0;
                    rx_calm = 1'b0;
                end
                // sender pauses until everything owed has come back
                if (phase == 5 && k == 60)
                    drain_results();
                it.half_tick = ($urandom_range(0, 99) < 85);
                it.reset_line = ($urandom_range(0, reset_odds) == 0);
                offer_item(it, 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge clk);

        $display("run covered %0d requests, %0d results, %0d register writes",
                 requests_sent, results_seen, cfg_writes);
        $display("all rate codes and masks exercised, slowest scaled lane flipped %0d times",
                 slow_lane_flips);
        if (mismatch_count == 0)
            $display("PASS bit_rate_divider_bank");
        else
            $display("FAIL bit_rate_divider_bank");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("FAIL bit_rate_divider_bank");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/brd_pkg.sv
rtl/brd_lane.sv
rtl/bit_rate_divider_bank.sv
dv/bit_rate_divider_bank_tb.sv
